[design/multichannel_moving_average_macros.svh]
// assertion macros for the moving average block and its checker
// no dependencies; the including module must provide i_clk and i_rst_n
`ifndef MULTICHANNEL_MOVING_AVERAGE_MACROS_SVH
`define MULTICHANNEL_MOVING_AVERAGE_MACROS_SVH

// clocked assertion, switched off while reset is held
`define MMAVG_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// clocked assertion that is also checked through reset
`define MMAVG_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[design/mmavg_pkg.sv]
// shared constants, widths and types of the moving average block
// no dependencies
package mmavg_pkg;

    localparam int WINDOW     = 10;
    localparam int CHANNELS   = 6;
    localparam int NUM_FIELDS = 6;
    localparam int DATA_W     = 24;

    // ring of WINDOW rows of CHANNELS samples
    localparam int DEPTH  = WINDOW * CHANNELS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);

    // running sum of up to WINDOW samples
    localparam int SUM_W = DATA_W + $clog2(WINDOW);

    // rounded division: (2*mag + d) / (2*d)
    localparam int NUM_W  = SUM_W + 2;
    localparam int DEN_W  = CNT_W + 1;
    localparam int STEP_W = $clog2(NUM_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } t_div_rsp;

endpackage

[design/mmavg_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
// depends on mmavg_pkg
module mmavg_div
    import mmavg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_quo;

    logic [DEN_W:0]    w_trial;
    logic              w_fits;
    logic [DEN_W:0]    w_diff;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        w_trial = {r_rem, r_quo[NUM_W-1]};
        w_fits  = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den <= i_req.den;
            r_rem <= '0;
            r_quo <= i_req.num;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

[design/multichannel_moving_average.sv]
// Each input transaction is handled channel by channel: a ring read, a sum update and NUM_W
// divider steps per channel, then all results go to the output register.
// A single bit-serial divider is shared by all channels. No new item is taken until the
// results are loaded, but the next one is taken while they wait in the output register.
// Reset (synchronous, active low) clears the running sums, write position and fill count;
// ring rows not yet written read as zero through the fill count, so no clearing pass.
module multichannel_moving_average
    import mmavg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [DATA_W-1:0] i_chan0_in,
    input  logic signed [DATA_W-1:0] i_chan1_in,
    input  logic signed [DATA_W-1:0] i_chan2_in,
    input  logic signed [DATA_W-1:0] i_chan3_in,
    input  logic signed [DATA_W-1:0] i_chan4_in,
    input  logic signed [DATA_W-1:0] i_chan5_in,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_chan0_avg,
    output logic signed [DATA_W-1:0] o_chan1_avg,
    output logic signed [DATA_W-1:0] o_chan2_avg,
    output logic signed [DATA_W-1:0] o_chan3_avg,
    output logic signed [DATA_W-1:0] o_chan4_avg,
    output logic signed [DATA_W-1:0] o_chan5_avg
);

    t_state r_state, n_state;

    logic signed [DATA_W-1:0] w_in  [0:NUM_FIELDS-1];
    logic signed [DATA_W-1:0] r_in  [0:CHANNELS-1];
    logic signed [DATA_W-1:0] r_res [0:CHANNELS-1];
    logic signed [DATA_W-1:0] r_avg [0:NUM_FIELDS-1];
    logic signed [SUM_W-1:0]  r_sum [0:CHANNELS-1];
    logic signed [DATA_W-1:0] r_mem [0:DEPTH-1];
    logic signed [DATA_W-1:0] r_rd;

    logic [CH_W-1:0]   r_ch;
    logic [ADDR_W-1:0] r_base;
    logic [CNT_W-1:0]  r_fill;
    logic              r_old_valid;
    logic              r_neg;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic              r_out_valid;

    logic                     w_in_acc;
    logic                     w_out_load;
    logic                     w_last_ch;
    logic [ADDR_W-1:0]        w_addr;
    logic signed [DATA_W-1:0] w_old;
    logic signed [SUM_W:0]    w_sum_wide;
    logic signed [SUM_W-1:0]  w_sum_new;
    logic                     w_neg;
    logic [SUM_W-1:0]         w_mag;
    logic [DATA_W-1:0]        w_q;
    t_div_req                 w_req;
    t_div_rsp                 w_rsp;

    assign w_in = '{i_chan0_in, i_chan1_in, i_chan2_in, i_chan3_in, i_chan4_in, i_chan5_in};

    // handshakes
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign w_last_ch   = (r_ch == CH_W'(CHANNELS - 1));

    // next state and strobes
    always_comb begin
        n_state    = r_state;
        w_out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                n_state = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (w_rsp.done) n_state = w_last_ch ? ST_DONE : ST_READ;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // ring memory, one row per sample time
    assign w_addr = r_base + ADDR_W'(r_ch);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPDATE) r_mem[w_addr] <= r_in[r_ch];
        if (r_state == ST_READ)   r_rd <= r_mem[w_addr];
    end

    // running sum update and divider operands
    always_comb begin
        w_old      = r_old_valid ? r_rd : '0;
        w_sum_wide = (SUM_W+1)'(r_sum[r_ch]) + (SUM_W+1)'(r_in[r_ch]) - (SUM_W+1)'(w_old);
        w_sum_new  = w_sum_wide[SUM_W-1:0];
        w_neg      = w_sum_new[SUM_W-1];
        w_mag      = w_neg ? SUM_W'(-w_sum_new) : SUM_W'(w_sum_new);
        w_q        = w_rsp.quo[DATA_W-1:0];
    end

    // control state: fill count, ring position, channel, running sums, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_base      <= '0;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
            r_old_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) r_sum[c] <= '0;
        end else begin
            if (w_in_acc) begin
                r_old_valid <= (r_fill == CNT_W'(WINDOW));
                if (r_fill != CNT_W'(WINDOW)) r_fill <= r_fill + 1'b1;
                r_ch <= '0;
            end
            if (r_state == ST_UPDATE) r_sum[r_ch] <= w_sum_new;
            if (r_state == ST_DIV_WAIT && w_rsp.done && !w_last_ch) r_ch <= r_ch + 1'b1;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                if (r_base == ADDR_W'((WINDOW - 1) * CHANNELS)) r_base <= '0;
                else r_base <= r_base + ADDR_W'(CHANNELS);
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            for (int c = 0; c < CHANNELS; c++) r_in[c] <= w_in[c];
        end
        if (r_state == ST_UPDATE) begin
            r_neg <= w_neg;
            r_num <= {1'b0, w_mag, 1'b0} + NUM_W'(r_fill);
            r_den <= {r_fill, 1'b0};
        end
        if (r_state == ST_DIV_WAIT && w_rsp.done) begin
            r_res[r_ch] <= r_neg ? -w_q : w_q;
        end
        if (w_out_load) begin
            for (int c = 0; c < NUM_FIELDS; c++) begin
                if (c < CHANNELS) r_avg[c] <= r_res[c];
                else              r_avg[c] <= '0;
            end
        end
    end

    // shared divider
    assign w_req.start = (r_state == ST_DIV_GO);
    assign w_req.num   = r_num;
    assign w_req.den   = r_den;

    mmavg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_chan0_avg = r_avg[0];
    assign o_chan1_avg = r_avg[1];
    assign o_chan2_avg = r_avg[2];
    assign o_chan3_avg = r_avg[3];
    assign o_chan4_avg = r_avg[4];
    assign o_chan5_avg = r_avg[5];

endmodule

[design/mmavg_checker.sv]
// port-level checks of the moving average block, bound to its top level
// depends on multichannel_moving_average_macros.svh
`include "multichannel_moving_average_macros.svh"

module mmavg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [23:0] o_chan0_avg,
    input logic [23:0] o_chan1_avg,
    input logic [23:0] o_chan2_avg,
    input logic [23:0] o_chan3_avg,
    input logic [23:0] o_chan4_avg,
    input logic [23:0] o_chan5_avg
);

    logic w_in_acc;

    assign w_in_acc = i_in_valid && !o_in_stall;

    // a transaction keeps the block busy in the next cycle
    `MMAVG_ASSERT_CLK(a_busy_after_accept, w_in_acc |=> o_in_stall, "block free after accept")

    // no result is pending straight after reset
    `MMAVG_ASSERT_RST(a_reset_clears_valid, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // a stalled result holds
    `MMAVG_ASSERT_CLK(a_out_hold,
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable({o_chan0_avg, o_chan1_avg, o_chan2_avg,
                                 o_chan3_avg, o_chan4_avg, o_chan5_avg})),
        "stalled result changed")

    // a result is never produced in the cycle after an input transaction
    `MMAVG_ASSERT_CLK(a_no_instant_result,
        (w_in_acc && !o_out_valid) |=> !o_out_valid,
        "result appeared too early")

endmodule

bind multichannel_moving_average mmavg_checker u_mmavg_checker (.*);
